// ===== design/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_SCROLL_PRIME,
        S_SCROLL
    } t_state;

    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam int          CELL_W       = 16;
    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;

    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 11;
    localparam int COL_W   = 7;
    localparam int LINE_W  = 5;

endpackage

`default_nettype wire

// ===== design/tcw_screen_ram.sv =====
`default_nettype none

module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [AW-1:0]     i_waddr,
    input  wire [CELL_W-1:0] i_wdata,
    input  wire              i_re,
    input  wire [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// put without scroll and func 3: result in the cycle after the transaction; read: result after S_READ
// put that scrolls: S_SCROLL_PRIME then S_SCROLL, one screen cell copied or blanked per memory cycle
// clear: S_CLEAR sweep, one cell blanked per cycle through the write port
// one transaction in flight at a time; a new one is taken once no result waits or in the
// cycle the waiting result is accepted
// after reset an S_INIT sweep blanks the screen memory with ready low
// reset is synchronous, active low; cursor homes to column 0, row 0
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [FUNC_W-1:0]    i_func,
    input  wire [BYTE_W-1:0]    i_char_code,
    input  wire [BYTE_W-1:0]    i_color,
    input  wire [INDEX_W-1:0]   i_cell_index,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [COL_W-1:0]    o_cursor_col,
    output logic [LINE_W-1:0]   o_cursor_line,
    output logic                o_scrolled,
    output logic [CELL_W-1:0]   o_cell_data
);

    localparam int N      = COLUMNS * ROWS;
    localparam int N_MOVE = N - COLUMNS;
    localparam int AW     = $clog2(N);
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic            r_o_valid, n_o_valid;
    logic            r_o_scrolled, n_o_scrolled;
    logic [CELL_W-1:0] r_o_data, n_o_data;
    logic            r_rd_hit, n_rd_hit;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic          w_accept;
    logic          w_last_col, w_last_row, w_sweep_end, w_rd_hit, w_move;
    logic [AW-1:0] w_put_addr;
    logic [31:0]   w_next_src;

    tcw_screen_ram #(
        .DEPTH (N),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready       = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign w_accept      = i_valid && o_ready;
    assign o_valid       = r_o_valid;
    assign o_cursor_col  = COL_W'(r_col);
    assign o_cursor_line = LINE_W'(r_row);
    assign o_scrolled    = r_o_scrolled;
    assign o_cell_data   = r_o_data;

    assign w_last_col  = (r_col == CW'(COLUMNS - 1));
    assign w_last_row  = (r_row == RW'(ROWS - 1));
    assign w_sweep_end = (r_addr == AW'(N - 1));
    assign w_rd_hit    = (32'(i_cell_index) < 32'(N));
    assign w_put_addr  = AW'(32'(r_row) * 32'(COLUMNS) + 32'(r_col));
    assign w_move      = (32'(r_addr) < 32'(N_MOVE));
    assign w_next_src  = 32'(r_addr) + 32'd1 + 32'(COLUMNS);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_col        = r_col;
        n_row        = r_row;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_scrolled = r_o_scrolled;
        n_o_data     = r_o_data;
        n_rd_hit     = r_rd_hit;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = BLANK_CELL;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (r_state) inside
            S_INIT, S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (w_sweep_end) begin
                    n_state = S_IDLE;
                    if (r_state == S_CLEAR) begin
                        n_o_valid    = 1'b1;
                        n_o_scrolled = 1'b0;
                        n_o_data     = '0;
                    end
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        FUNC_PUT: begin
                            n_o_scrolled = 1'b0;
                            n_o_data     = '0;
                            if (i_char_code == NEWLINE_CODE) begin
                                n_col = '0;
                                if (w_last_row) begin
                                    n_state = S_SCROLL_PRIME;
                                end else begin
                                    n_row     = r_row + RW'(1);
                                    n_o_valid = 1'b1;
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = w_put_addr;
                                ram_wdata = {i_color, i_char_code};
                                if (w_last_col) begin
                                    n_col = '0;
                                    if (w_last_row) begin
                                        n_state = S_SCROLL_PRIME;
                                    end else begin
                                        n_row     = r_row + RW'(1);
                                        n_o_valid = 1'b1;
                                    end
                                end else begin
                                    n_col     = r_col + CW'(1);
                                    n_o_valid = 1'b1;
                                end
                            end
                        end
                        FUNC_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                        FUNC_READ: begin
                            ram_re    = w_rd_hit;
                            ram_raddr = AW'(i_cell_index);
                            n_rd_hit  = w_rd_hit;
                            n_state   = S_READ;
                        end
                        default: begin
                            n_o_valid    = 1'b1;
                            n_o_scrolled = 1'b0;
                            n_o_data     = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_o_valid    = 1'b1;
                n_o_scrolled = 1'b0;
                n_o_data     = r_rd_hit ? ram_rdata : '0;
                n_state      = S_IDLE;
            end
            S_SCROLL_PRIME: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(COLUMNS);
                n_addr    = '0;
                n_state   = S_SCROLL;
            end
            S_SCROLL: begin
                // row above takes the cell read in the cycle before, last row goes blank
                ram_we    = 1'b1;
                ram_wdata = w_move ? ram_rdata : BLANK_CELL;
                ram_re    = (w_next_src < 32'(N));
                ram_raddr = AW'(w_next_src);
                n_addr    = r_addr + AW'(1);
                if (w_sweep_end) begin
                    n_row        = RW'(ROWS - 1);
                    n_o_valid    = 1'b1;
                    n_o_scrolled = 1'b1;
                    n_o_data     = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_addr    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
            r_rd_hit  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_col     <= n_col;
            r_row     <= n_row;
            r_o_valid <= n_o_valid;
            r_rd_hit  <= n_rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_scrolled <= n_o_scrolled;
        r_o_data     <= n_o_data;
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(ROWS))
        else $error("cursor row out of range");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scrolled |-> o_cursor_col == '0 && o_cursor_line == LINE_W'(ROWS - 1))
        else $error("scroll result with cursor off the last row start");

    a_data_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cell_data != '0 |-> !o_scrolled)
        else $error("cell data on a scrolling transaction");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_func == FUNC_CLEAR |=> !o_valid && r_state == S_CLEAR)
        else $error("clear did not start its sweep");

endmodule

`default_nettype wire

// ===== sim/text_console_writer_tb.sv =====
`timescale 1ns / 100ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = COLUMNS * ROWS;
    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    // func 3 has no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic              scrolled;
        logic [CELL_W-1:0] data;
    } t_console_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func;
    logic [BYTE_W-1:0]   i_char_code;
    logic [BYTE_W-1:0]   i_color;
    logic [INDEX_W-1:0]  i_cell_index;
    logic                o_valid;
    logic                i_ready;
    logic [COL_W-1:0]    o_cursor_col;
    logic [LINE_W-1:0]   o_cursor_line;
    logic                o_scrolled;
    logic [CELL_W-1:0]   o_cell_data;

    logic [CELL_W-1:0]   shadow_screen [0:CELL_COUNT-1];
    int unsigned         shadow_col;
    int unsigned         shadow_row;
    t_console_result     pending_results [$];

    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;
    int                  send_idle = 0;
    int                  recv_idle = 0;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  hold_left = 0;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_color      (i_color),
        .i_cell_index (i_cell_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_col (o_cursor_col),
        .o_cursor_line(o_cursor_line),
        .o_scrolled   (o_scrolled),
        .o_cell_data  (o_cell_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void home_shadow();
        for (int i = 0; i < CELL_COUNT; i++) begin
            shadow_screen[i] = BLANK_CELL;
        end
        shadow_col = 0;
        shadow_row = 0;
    endfunction

    function automatic t_console_result predict_console(
        input logic [FUNC_W-1:0]  f,
        input logic [BYTE_W-1:0]  code,
        input logic [BYTE_W-1:0]  attr,
        input logic [INDEX_W-1:0] idx
    );
        t_console_result res;
        res = '0;
        case (f)
            FUNC_PUT: begin
                if (code == NEWLINE_CODE) begin
                    shadow_col = 0;
                    shadow_row++;
                end else begin
                    shadow_screen[shadow_row * COLUMNS + shadow_col] = {attr, code};
                    shadow_col++;
                    if (shadow_col >= COLUMNS) begin
                        shadow_col = 0;
                        shadow_row++;
                    end
                end
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    end
                    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
                        shadow_screen[i] = BLANK_CELL;
                    end
                    shadow_row = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                home_shadow();
            end
            FUNC_READ: begin
                if (idx < CELL_COUNT) begin
                    res.data = shadow_screen[idx];
                end
            end
            default: begin
            end
        endcase
        res.col  = COL_W'(shadow_col);
        res.line = LINE_W'(shadow_row);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // checks results and predicts accepted transactions, both on pre-edge values
    always @(posedge i_clk) begin
        t_console_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_cursor_col !== want.col)
                        report_mismatch("cursor_col", o_cursor_col, want.col);
                    if (o_cursor_line !== want.line)
                        report_mismatch("cursor_line", o_cursor_line, want.line);
                    if (o_scrolled !== want.scrolled)
                        report_mismatch("scrolled", o_scrolled, want.scrolled);
                    if (o_cell_data !== want.data)
                        report_mismatch("cell_data", o_cell_data, want.data);
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(
                    predict_console(i_func, i_char_code, i_color, i_cell_index));
            end
            if ((o_valid && i_ready) || (i_valid && o_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("text_console_writer: mismatch");
        $finish;
    end

    task automatic send_op(
        input logic [FUNC_W-1:0]  f,
        input logic [BYTE_W-1:0]  code,
        input logic [BYTE_W-1:0]  attr,
        input logic [INDEX_W-1:0] idx
    );
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= f;
        i_char_code  <= code;
        i_color      <= attr;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_glyph();
        logic [BYTE_W-1:0] code;
        do code = BYTE_W'($urandom_range(255)); while (code == NEWLINE_CODE);
        return code;
    endfunction

    task automatic put_char(input logic [BYTE_W-1:0] code);
        send_op(FUNC_PUT, code, BYTE_W'($urandom_range(255)),
                INDEX_W'($urandom_range(2047)));
    endtask

    task automatic read_cell(input int idx);
        send_op(FUNC_READ, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                INDEX_W'(idx));
    endtask

    task automatic test_directed();
        read_cell(0);
        read_cell(CELL_COUNT - 1);
        read_cell(CELL_COUNT);
        read_cell(2047);
        send_op(FUNC_NONE, 8'hFF, 8'hFF, 11'h7FF);
        send_op(FUNC_NONE, 8'h00, 8'h00, 11'h000);
        send_op(FUNC_PUT, 8'h00, 8'h00, 11'h000);
        send_op(FUNC_PUT, 8'hFF, 8'hFF, 11'h7FF);
        send_op(FUNC_PUT, 8'h20, 8'h0F, 11'h000);
        send_op(FUNC_PUT, NEWLINE_CODE, 8'hFF, 11'h7FF);
        send_op(FUNC_PUT, 8'h41, 8'h1E, 11'h000);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(3);
        read_cell(COLUMNS);
        read_cell(COLUMNS + 1);
        send_op(FUNC_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
        read_cell(0);
        read_cell(COLUMNS);
    endtask

    task automatic test_row_wrap();
        send_op(FUNC_CLEAR, 8'h00, 8'h00, 11'h000);
        put_char(rand_glyph());
        for (int i = 0; i < COLUMNS; i++) begin
            put_char(rand_glyph());
        end
        read_cell(0);
        read_cell(COLUMNS - 1);
        read_cell(COLUMNS);
        read_cell(COLUMNS + 1);
        for (int i = 0; i < 6; i++) begin
            read_cell($urandom_range(2 * COLUMNS - 1));
        end
    endtask

    task automatic test_scroll();
        send_op(FUNC_CLEAR, 8'h00, 8'h00, 11'h000);
        while (shadow_row < ROWS - 1) begin
            repeat ($urandom_range(6)) put_char(rand_glyph());
            put_char(NEWLINE_CODE);
        end
        // fill the bottom row so the last column wraps and scrolls
        repeat (COLUMNS) put_char(rand_glyph());
        read_cell((ROWS - 2) * COLUMNS);
        read_cell(CELL_COUNT - COLUMNS);
        read_cell(CELL_COUNT - 1);
        repeat (3) put_char(rand_glyph());
        put_char(NEWLINE_CODE);
        read_cell((ROWS - 2) * COLUMNS + 1);
        read_cell(CELL_COUNT - COLUMNS);
        read_cell(0);
        put_char(NEWLINE_CODE);
        read_cell((ROWS - 3) * COLUMNS);
    endtask

    task automatic random_op();
        int r;
        int idx;
        r = $urandom_range(999);
        if (r < 600) begin
            put_char(BYTE_W'($urandom_range(255)));
        end else if (r < 660) begin
            put_char(NEWLINE_CODE);
        end else if (r < 662) begin
            send_op(FUNC_CLEAR, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                    INDEX_W'($urandom_range(2047)));
        end else if (r < 682) begin
            send_op(FUNC_NONE, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                    INDEX_W'($urandom_range(2047)));
        end else begin
            case ($urandom_range(3))
                0: idx = shadow_row * COLUMNS + $urandom_range(COLUMNS - 1);
                1: idx = $urandom_range(CELL_COUNT - 1);
                2: idx = (shadow_row > 0 ? shadow_row - 1 : 0) * COLUMNS
                         + $urandom_range(COLUMNS - 1);
                default: idx = $urandom_range(2047);
            endcase
            read_cell(idx);
        end
    endtask

    task automatic test_random(input int count);
        repeat (count) random_op();
    endtask

    task automatic test_backpressure();
        hold_requests++;
        repeat (12) random_op();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_ready      = 1'b0;
        i_func       = FUNC_PUT;
        i_char_code  = '0;
        i_color      = '0;
        i_cell_index = '0;
        home_shadow();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 24;
        recv_idle = 73;
        test_directed();
        test_row_wrap();
        test_scroll();
        test_random(350);

        send_idle = 73;
        recv_idle = 24;
        test_backpressure();
        test_random(350);

        send_idle = 0;
        recv_idle = 0;
        test_backpressure();
        test_random(300);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("text_console_writer: match");
        end else begin
            $display("text_console_writer: mismatch");
        end
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
design/tcw_pkg.sv
design/tcw_screen_ram.sv
design/text_console_writer.sv
sim/text_console_writer_tb.sv
